// ----- design/dlms_pkg.sv -----
`timescale 1ns / 1ps

package dlms_pkg;

	localparam int STATE_W = 6;
	localparam int CHAR_W  = 8;
	localparam int ID_W    = 8;
	localparam int ANCH_W  = 4;
	localparam int LEN_W   = 16;

	// request codes
	localparam logic [2:0] REQ_LOAD_NEXT = 3'd0;
	localparam logic [2:0] REQ_LOAD_ATTR = 3'd1;
	localparam logic [2:0] REQ_START     = 3'd2;
	localparam logic [2:0] REQ_BYTE      = 3'd3;
	localparam logic [2:0] REQ_END       = 3'd4;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [STATE_W-1:0] state_index;
		logic [CHAR_W-1:0]  char_code;
		logic [STATE_W-1:0] target_state;
		logic               target_valid;
		logic               accept_valid;
		logic [ID_W-1:0]    accept_id;
		logic               stop_on_accept;
		logic [ANCH_W-1:0]  anchor_bits;
	} req_t;

	typedef struct packed {
		logic              match_found;
		logic [ID_W-1:0]   match_id;
		logic [LEN_W-1:0]  match_len;
		logic [ANCH_W-1:0] match_anchor;
	} res_t;

	typedef struct packed {
		logic              acc;
		logic [ID_W-1:0]   id;
		logic              stop;
		logic [ANCH_W-1:0] anchor;
	} attr_t;

endpackage

// ----- design/dlms_ram.sv -----
`timescale 1ns / 1ps

module dlms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ----- design/dfa_longest_match_scanner.sv -----
`timescale 1ns / 1ps
// A result is presented on res_valid after the transfer of the item that ends the scan,
// passing through the next-state read, the attribute read and the result register.
// Throughput: one item per cycle unless a result waits; the next-state read feeds
// the next byte's address directly, so back-to-back text bytes run without bubbles.
// Reset: asynchronous; afterwards both tables are cleared, one entry per cycle, with
// req_ready held low until every next-state table address has been written.
module dfa_longest_match_scanner #(
	parameter int NUM_STATES    = 64,
	parameter int ALPHABET_SIZE = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  dlms_pkg::req_t  req_data,
	output logic            res_valid,
	input  logic            res_ready,
	output dlms_pkg::res_t  res_data
);

	import dlms_pkg::*;

	localparam int NS_EFF = (NUM_STATES < (1 << STATE_W)) ? NUM_STATES : (1 << STATE_W);
	localparam int AL_EFF = (ALPHABET_SIZE < (1 << CHAR_W)) ? ALPHABET_SIZE : (1 << CHAR_W);
	localparam int SW     = $clog2(NS_EFF);
	localparam int CW     = $clog2(AL_EFF);
	localparam int NW     = SW + CW;
	localparam int ATTR_W = $bits(attr_t);
	localparam logic [STATE_W:0] NS_LIM = (STATE_W + 1)'(NS_EFF);
	localparam logic [CHAR_W:0]  AL_LIM = (CHAR_W + 1)'(AL_EFF);

	// clearing pass
	logic          clr_busy_q;
	logic [NW-1:0] clr_q;

	// stage 0 (transfer cycle)
	logic          take, en;
	logic          st_in, ch_in, tgt_ok;
	logic [SW-1:0] cur_q, cur_eff;

	// next-state table: {valid, target}
	logic          nst_we, nst_re;
	logic [NW-1:0] nst_addr;
	logic [SW:0]   nst_wdata, nst_rd;

	// stage 1
	logic          vld_s1, chok_s1, ld_ok_s1;
	logic [2:0]    req_s1;
	logic [SW-1:0] ld_idx_s1;
	attr_t         ld_attr_s1;

	// attribute table
	logic          attr_we, attr_re;
	logic [SW-1:0] attr_addr;
	attr_t         attr_wdata, attr_rd;
	logic [ATTR_W-1:0] attr_rd_raw;

	// stage 2
	logic          vld_s2, chok_s2, nvld_s2;
	logic [2:0]    req_s2;

	// scan state
	logic             active_q, active_n;
	logic [LEN_W-1:0] len_q, len_n;
	res_t             best_q, best_n;
	logic             fin;

	res_t res_q;
	logic res_valid_q;

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	assign en        = !(fin && res_valid_q && !res_ready);
	assign req_ready = en && !clr_busy_q;
	assign take      = req_valid && req_ready;

	assign st_in  = {1'b0, req_data.state_index} < NS_LIM;
	assign ch_in  = {1'b0, req_data.char_code} < AL_LIM;
	assign tgt_ok = req_data.target_valid && ({1'b0, req_data.target_state} < NS_LIM);

	// state after the byte now in stage 1, else the held state
	assign cur_eff = (vld_s1 && req_s1 == REQ_BYTE) ? nst_rd[SW-1:0] : cur_q;

	always_comb begin
		nst_we    = 1'b0;
		nst_re    = 1'b0;
		nst_wdata = '0;
		nst_addr  = {cur_eff, req_data.char_code[CW-1:0]};
		if (clr_busy_q) begin
			nst_we   = 1'b1;
			nst_addr = clr_q;
		end else if (take && req_data.req_type == REQ_LOAD_NEXT) begin
			nst_we    = st_in && ch_in;
			nst_addr  = {req_data.state_index[SW-1:0], req_data.char_code[CW-1:0]};
			nst_wdata = {tgt_ok, tgt_ok ? req_data.target_state[SW-1:0] : {SW{1'b0}}};
		end else if (take && req_data.req_type == REQ_BYTE) begin
			nst_re = 1'b1;
		end
	end

	dlms_ram #(.WIDTH(SW + 1), .DEPTH(1 << NW)) u_nst_ram (
		.clk   (clk),
		.we    (nst_we),
		.re    (nst_re),
		.addr  (nst_addr),
		.wdata (nst_wdata),
		.rdata (nst_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (&clr_q) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			cur_q  <= (take && req_data.req_type == REQ_START) ? {SW{1'b0}} : cur_eff;
			vld_s1 <= take;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s1     <= req_data.req_type;
			chok_s1    <= ch_in;
			ld_ok_s1   <= st_in;
			ld_idx_s1  <= req_data.state_index[SW-1:0];
			ld_attr_s1 <= '{acc: req_data.accept_valid, id: req_data.accept_id,
				stop: req_data.stop_on_accept, anchor: req_data.anchor_bits};
			req_s2     <= req_s1;
			chok_s2    <= chok_s1;
			nvld_s2    <= nst_rd[SW];
		end
	end

	// stage 1: attribute write for loads, read of the arrival state for scans
	always_comb begin
		attr_we    = 1'b0;
		attr_re    = 1'b0;
		attr_wdata = ld_attr_s1;
		attr_addr  = '0;
		if (clr_busy_q) begin
			attr_we    = 1'b1;
			attr_wdata = '0;
			attr_addr  = clr_q[SW-1:0];
		end else if (en && vld_s1) begin
			case (req_s1)
				REQ_LOAD_ATTR: begin
					attr_we   = ld_ok_s1;
					attr_addr = ld_idx_s1;
				end
				REQ_BYTE: begin
					attr_re   = 1'b1;
					attr_addr = nst_rd[SW-1:0];
				end
				REQ_START: begin
					attr_re = 1'b1;
				end
				default: begin
					attr_re = 1'b0;
				end
			endcase
		end
	end

	dlms_ram #(.WIDTH(ATTR_W), .DEPTH(1 << SW)) u_attr_ram (
		.clk   (clk),
		.we    (attr_we),
		.re    (attr_re),
		.addr  (attr_addr),
		.wdata (attr_wdata),
		.rdata (attr_rd_raw)
	);

	assign attr_rd = attr_t'(attr_rd_raw);

	// stage 2: commit in item order; bytes that follow a finished scan are dropped here
	always_comb begin
		fin      = 1'b0;
		active_n = active_q;
		len_n    = len_q;
		best_n   = best_q;
		if (vld_s2) begin
			case (req_s2)
				REQ_START: begin
					len_n  = '0;
					best_n = '0;
					if (attr_rd.acc) begin
						best_n = '{match_found: 1'b1, match_id: attr_rd.id,
							match_len: '0, match_anchor: attr_rd.anchor};
					end
					fin      = attr_rd.acc && attr_rd.stop;
					active_n = !fin;
				end
				REQ_BYTE: begin
					if (active_q) begin
						if (!chok_s2 || !nvld_s2) begin
							fin = 1'b1;
						end else begin
							len_n = (&len_q) ? len_q : len_q + 1'b1;
							if (attr_rd.acc) begin
								best_n = '{match_found: 1'b1, match_id: attr_rd.id,
									match_len: len_n, match_anchor: attr_rd.anchor};
							end
							fin = attr_rd.acc && attr_rd.stop;
						end
						active_n = !fin;
					end
				end
				REQ_END: begin
					fin      = active_q;
					active_n = 1'b0;
				end
				default: begin
					fin = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			len_q       <= '0;
			best_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (en) begin
				active_q <= active_n;
				len_q    <= len_n;
				best_q   <= best_n;
			end
			if (en && fin) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && fin) begin
			res_q <= best_n;
		end
	end

	// the pipeline stays empty while the tables are being cleared
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !vld_s1 && !vld_s2)
		else $error("item in pipeline during table clear");

	// no match means all match fields are zero
	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.match_found |->
			res_data.match_id == '0 && res_data.match_len == '0 &&
			res_data.match_anchor == '0)
		else $error("nonzero fields without a match");

	// a stall only happens behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!en |-> res_valid_q && vld_s2)
		else $error("pipeline stalled without a pending result");

	// a result leaves the scan idle
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		en && fin |=> !active_q)
		else $error("scan still active after its result");

endmodule
